>>> design/fpa_pkg.sv
package fpa_pkg;

  localparam int NUM_PARTITIONS = 16;
  localparam int IDX_W = $clog2(NUM_PARTITIONS);
  localparam int CNT_W = $clog2(NUM_PARTITIONS + 1);

  localparam int CMD_W   = 2;
  localparam int PIDX_W  = 4;
  localparam int SIZE_W  = 16;
  localparam int BASE_W  = 20;
  localparam int JOB_W   = 8;
  localparam int STAT_W  = 2;
  localparam int GIDX_W  = 4;
  localparam int FREED_W = 5;
  localparam int PCNT_W  = 5;

  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REL   = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOFIT  = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOTFND = 2'd2;
  localparam logic [STAT_W-1:0] ST_BAD    = 2'd3;

  localparam logic [JOB_W-1:0] JOB_FREE = '0;

  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic [BASE_W-1:0] base;
  } geom_t;

  typedef struct packed {
    logic [IDX_W-1:0] rd_addr;
    logic             ld_we;
    logic [IDX_W-1:0] ld_addr;
    geom_t            ld_data;
    logic             own_we;
    logic [IDX_W-1:0] own_addr;
    logic [JOB_W-1:0] own_data;
  } tbl_req_t;

  typedef struct packed {
    geom_t            geom;
    logic [JOB_W-1:0] owner;
  } tbl_rsp_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [GIDX_W-1:0]  granted_index;
    logic [BASE_W-1:0]  granted_base;
    logic [FREED_W-1:0] freed_count;
  } res_t;

endpackage

>>> design/fpa_table.sv
module fpa_table import fpa_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  tbl_req_t req,
  output tbl_rsp_t rsp
);

  geom_t                     geom_mem_r [NUM_PARTITIONS];
  logic [JOB_W-1:0]          own_mem_r  [NUM_PARTITIONS];
  logic [NUM_PARTITIONS-1:0] own_vld_r;
  logic [NUM_PARTITIONS-1:0] own_vld_nxt;
  geom_t                     geom_q_r;
  logic [JOB_W-1:0]          own_q_r;
  logic                      vld_q_r;

  // geometry and owner memories, registered read
  always_ff @(posedge clk) begin
    if (req.ld_we) begin
      geom_mem_r[req.ld_addr] <= req.ld_data;
    end
    if (req.own_we) begin
      own_mem_r[req.own_addr] <= req.own_data;
    end
    geom_q_r <= geom_mem_r[req.rd_addr];
    own_q_r  <= own_mem_r[req.rd_addr];
  end

  // owner entries not yet written read as free
  always_comb begin
    own_vld_nxt = own_vld_r;
    if (req.own_we) begin
      own_vld_nxt[req.own_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_vld_r <= '0;
      vld_q_r   <= 1'b0;
    end else begin
      own_vld_r <= own_vld_nxt;
      vld_q_r   <= own_vld_r[req.rd_addr];
    end
  end

  assign rsp.geom  = geom_q_r;
  assign rsp.owner = vld_q_r ? own_q_r : JOB_FREE;

endmodule

>>> design/fpa_scan.sv
module fpa_scan import fpa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CMD_W-1:0]  in_cmd,
  input  logic [PIDX_W-1:0] in_part_index,
  input  logic [SIZE_W-1:0] in_part_size,
  input  logic [BASE_W-1:0] in_part_base,
  input  logic [JOB_W-1:0]  in_job_id,
  input  logic [SIZE_W-1:0] in_job_size,
  input  logic [PCNT_W-1:0] part_count,
  output tbl_req_t          tbl_req,
  input  tbl_rsp_t          tbl_rsp,
  output logic              res_valid,
  input  logic              res_take,
  output res_t              res
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_RESP = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  logic [CMD_W-1:0]   cmd_r, cmd_nxt;
  logic [JOB_W-1:0]   job_r, job_nxt;
  logic [SIZE_W-1:0]  jsize_r, jsize_nxt;
  logic [CNT_W-1:0]   lim_r, lim_nxt;
  logic [IDX_W-1:0]   ptr_r, ptr_nxt;
  logic [FREED_W-1:0] freed_r, freed_nxt;
  res_t               res_r, res_nxt;

  logic [CNT_W-1:0]   lim_in;
  logic               accept;
  logic               last;
  logic               fit;
  logic               match;
  logic [FREED_W-1:0] freed_sum;

  assign accept   = in_valid && (state_r == S_IDLE);
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    if (part_count > PCNT_W'(NUM_PARTITIONS)) begin
      lim_in = CNT_W'(NUM_PARTITIONS);
    end else begin
      lim_in = CNT_W'(part_count);
    end
  end

  // data for entry ptr_r is on the read port while entry ptr_r+1 is being read
  assign last      = (CNT_W'(ptr_r) + CNT_W'(1)) == lim_r;
  assign fit       = (tbl_rsp.owner == JOB_FREE) && (tbl_rsp.geom.size >= jsize_r);
  assign match     = (tbl_rsp.owner == job_r);
  assign freed_sum = freed_r + FREED_W'(match);

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    job_nxt   = job_r;
    jsize_nxt = jsize_r;
    lim_nxt   = lim_r;
    ptr_nxt   = ptr_r;
    freed_nxt = freed_r;
    res_nxt   = res_r;

    tbl_req              = '0;
    tbl_req.ld_addr      = IDX_W'(in_part_index);
    tbl_req.ld_data.size = in_part_size;
    tbl_req.ld_data.base = in_part_base;
    tbl_req.own_addr     = ptr_r;
    tbl_req.rd_addr      = (state_r == S_SCAN) ? ptr_r + IDX_W'(1) : '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt   = in_cmd;
          job_nxt   = in_job_id;
          jsize_nxt = in_job_size;
          lim_nxt   = lim_in;
          ptr_nxt   = '0;
          freed_nxt = '0;
          res_nxt   = '0;
          state_nxt = S_RESP;
          case (in_cmd)
            CMD_LOAD: begin
              if (32'(in_part_index) < NUM_PARTITIONS) begin
                tbl_req.ld_we    = 1'b1;
                tbl_req.own_we   = 1'b1;
                tbl_req.own_addr = IDX_W'(in_part_index);
                tbl_req.own_data = JOB_FREE;
              end else begin
                res_nxt.status = ST_BAD;
              end
            end
            CMD_ALLOC, CMD_REL: begin
              if (in_job_id == JOB_FREE) begin
                res_nxt.status = ST_BAD;
              end else if (lim_in == '0) begin
                res_nxt.status = (in_cmd == CMD_ALLOC) ? ST_NOFIT : ST_NOTFND;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            default: begin
              res_nxt.status = ST_BAD;
            end
          endcase
        end
      end
      S_SCAN: begin
        ptr_nxt = ptr_r + IDX_W'(1);
        if (cmd_r == CMD_ALLOC) begin
          if (fit) begin
            tbl_req.own_we        = 1'b1;
            tbl_req.own_data      = job_r;
            res_nxt.status        = ST_OK;
            res_nxt.granted_index = GIDX_W'(ptr_r);
            res_nxt.granted_base  = tbl_rsp.geom.base;
            state_nxt             = S_RESP;
          end else if (last) begin
            res_nxt.status = ST_NOFIT;
            state_nxt      = S_RESP;
          end
        end else begin
          tbl_req.own_we   = match;
          tbl_req.own_data = JOB_FREE;
          freed_nxt        = freed_sum;
          if (last) begin
            res_nxt.freed_count = freed_sum;
            res_nxt.status      = (freed_sum == '0) ? ST_NOTFND : ST_OK;
            state_nxt           = S_RESP;
          end
        end
      end
      S_RESP: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    job_r   <= job_nxt;
    jsize_r <= jsize_nxt;
    lim_r   <= lim_nxt;
    ptr_r   <= ptr_nxt;
    freed_r <= freed_nxt;
    res_r   <= res_nxt;
  end

  assign res_valid = (state_r == S_RESP);
  assign res       = res_r;

`ifndef ASSERT_OFF
  a_resp_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP) && !res_take |=> (state_r == S_RESP) && $stable(res_r))
    else $error("result changed before it was taken");

  a_own_we_state: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_req.own_we |-> (state_r == S_IDLE) || (state_r == S_SCAN))
    else $error("owner write outside load or scan");

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (CNT_W'(ptr_r) < lim_r))
    else $error("scan pointer beyond partition count");

  a_freed_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP) && (cmd_r == CMD_REL) |-> (CNT_W'(res_r.freed_count) <= lim_r))
    else $error("freed count exceeds scanned partitions");
`endif

endmodule

>>> design/fixed_partition_first_fit_allocator.sv
// channel  direction  handshake              payload
// in       input      in_valid / in_stall    cmd, part_index, part_size, part_base,
//                                            job_id, job_size
// out      output     out_valid / out_stall  status, granted_index, granted_base,
//                                            freed_count
// cfg      input      cfg_we                 cfg_wdata = partition_count
//
// load and rejected items go from idle straight to the result state; allocate and
// release scan n entries, n up to partition_count capped at 16, with one
// owner-table read per cycle.
// one item is in work at a time; the output register lets the next item in
// while a result waits on out_stall.
// reset clears partition_count and the owner valid flags at once, no clearing pass.
module fixed_partition_first_fit_allocator import fpa_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [CMD_W-1:0]   in_cmd,
  input  logic [PIDX_W-1:0]  in_part_index,
  input  logic [SIZE_W-1:0]  in_part_size,
  input  logic [BASE_W-1:0]  in_part_base,
  input  logic [JOB_W-1:0]   in_job_id,
  input  logic [SIZE_W-1:0]  in_job_size,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [STAT_W-1:0]  out_status,
  output logic [GIDX_W-1:0]  out_granted_index,
  output logic [BASE_W-1:0]  out_granted_base,
  output logic [FREED_W-1:0] out_freed_count,
  input  logic               cfg_we,
  input  logic [PCNT_W-1:0]  cfg_wdata
);

  logic [PCNT_W-1:0] part_count_r;
  logic              out_valid_r;
  res_t              out_res_r;
  tbl_req_t          tbl_req;
  tbl_rsp_t          tbl_rsp;
  logic              res_valid;
  logic              res_take;
  res_t              res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      part_count_r <= '0;
    end else if (cfg_we) begin
      part_count_r <= cfg_wdata;
    end
  end

  fpa_table u_table (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (tbl_req),
    .rsp   (tbl_rsp)
  );

  fpa_scan u_scan (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cmd        (in_cmd),
    .in_part_index (in_part_index),
    .in_part_size  (in_part_size),
    .in_part_base  (in_part_base),
    .in_job_id     (in_job_id),
    .in_job_size   (in_job_size),
    .part_count    (part_count_r),
    .tbl_req       (tbl_req),
    .tbl_rsp       (tbl_rsp),
    .res_valid     (res_valid),
    .res_take      (res_take),
    .res           (res)
  );

  // output beat register
  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_res_r.status;
  assign out_granted_index = out_res_r.granted_index;
  assign out_granted_base  = out_res_r.granted_base;
  assign out_freed_count   = out_res_r.freed_count;

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps

module tb;
  import fpa_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 20;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int NUM_PHASES = 10;
  localparam int PHASE_ITEMS = 60;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [PIDX_W-1:0] part_index;
    logic [SIZE_W-1:0] part_size;
    logic [BASE_W-1:0] part_base;
    logic [JOB_W-1:0]  job_id;
    logic [SIZE_W-1:0] job_size;
  } req_t;

  typedef enum {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    logic [PCNT_W-1:0] count;
    req_t              req;
    bit                typed;
    res_t              res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CMD_W-1:0] in_cmd = '0;
  logic [PIDX_W-1:0] in_part_index = '0;
  logic [SIZE_W-1:0] in_part_size = '0;
  logic [BASE_W-1:0] in_part_base = '0;
  logic [JOB_W-1:0] in_job_id = '0;
  logic [SIZE_W-1:0] in_job_size = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [STAT_W-1:0] out_status;
  logic [GIDX_W-1:0] out_granted_index;
  logic [BASE_W-1:0] out_granted_base;
  logic [FREED_W-1:0] out_freed_count;
  logic cfg_we = 1'b0;
  logic [PCNT_W-1:0] cfg_wdata = '0;

  // shadow of the partition table
  logic [SIZE_W-1:0] part_size_tab [NUM_PARTITIONS];
  logic [BASE_W-1:0] part_base_tab [NUM_PARTITIONS];
  logic [JOB_W-1:0]  part_owner_tab [NUM_PARTITIONS];
  logic [PCNT_W-1:0] scan_count = '0;

  res_t pending_res [$];
  stim_row_t stim_rows [$];
  res_t want_res;
  int err_cnt = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  int stall_left = 0;
  int idle_cycles = 0;

  fixed_partition_first_fit_allocator u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_cmd            (in_cmd),
    .in_part_index     (in_part_index),
    .in_part_size      (in_part_size),
    .in_part_base      (in_part_base),
    .in_job_id         (in_job_id),
    .in_job_size       (in_job_size),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_granted_index (out_granted_index),
    .out_granted_base  (out_granted_base),
    .out_freed_count   (out_freed_count),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    for (int i = 0; i < NUM_PARTITIONS; i++) begin
      part_owner_tab[i] = JOB_FREE;
    end
  end

  function automatic res_t alloc_outcome(input req_t r);
    res_t o;
    int lim;
    int freed;
    int i;
    bit found;
    o = '0;
    freed = 0;
    found = 1'b0;
    lim = (scan_count > NUM_PARTITIONS) ? NUM_PARTITIONS : int'(scan_count);
    case (r.cmd)
      CMD_LOAD: begin
        // part_index is 4 bits wide, so every load lands in the table
        part_size_tab[r.part_index] = r.part_size;
        part_base_tab[r.part_index] = r.part_base;
        part_owner_tab[r.part_index] = JOB_FREE;
        o.status = ST_OK;
      end
      CMD_ALLOC: begin
        if (r.job_id == JOB_FREE) begin
          o.status = ST_BAD;
        end else begin
          o.status = ST_NOFIT;
          for (i = 0; i < lim; i++) begin
            if (!found && part_owner_tab[i] == JOB_FREE && part_size_tab[i] >= r.job_size) begin
              found = 1'b1;
              part_owner_tab[i] = r.job_id;
              o.status = ST_OK;
              o.granted_index = i[GIDX_W-1:0];
              o.granted_base = part_base_tab[i];
            end
          end
        end
      end
      CMD_REL: begin
        if (r.job_id == JOB_FREE) begin
          o.status = ST_BAD;
        end else begin
          for (i = 0; i < lim; i++) begin
            if (part_owner_tab[i] == r.job_id) begin
              part_owner_tab[i] = JOB_FREE;
              freed++;
            end
          end
          o.status = (freed == 0) ? ST_NOTFND : ST_OK;
          o.freed_count = freed[FREED_W-1:0];
        end
      end
      default: begin
        o.status = ST_BAD;
      end
    endcase
    return o;
  endfunction

  function automatic req_t mk_req(input logic [CMD_W-1:0] cmd, input int pidx, input int psize,
                                  input int pbase, input int job, input int jsize);
    req_t r;
    r.cmd = cmd;
    r.part_index = pidx[PIDX_W-1:0];
    r.part_size = psize[SIZE_W-1:0];
    r.part_base = pbase[BASE_W-1:0];
    r.job_id = job[JOB_W-1:0];
    r.job_size = jsize[SIZE_W-1:0];
    return r;
  endfunction

  function automatic res_t mk_res(input logic [STAT_W-1:0] st, input int gidx, input int gbase,
                                  input int freed);
    res_t o;
    o.status = st;
    o.granted_index = gidx[GIDX_W-1:0];
    o.granted_base = gbase[BASE_W-1:0];
    o.freed_count = freed[FREED_W-1:0];
    return o;
  endfunction

  function automatic void add_item(input req_t r, input bit typed, input res_t o);
    stim_row_t row;
    row.kind = ROW_ITEM;
    row.count = '0;
    row.req = r;
    row.typed = typed;
    row.res = o;
    stim_rows.push_back(row);
  endfunction

  function automatic void add_cfg(input int cnt);
    stim_row_t row;
    row.kind = ROW_CFG;
    row.count = cnt[PCNT_W-1:0];
    row.req = '0;
    row.typed = 1'b0;
    row.res = '0;
    stim_rows.push_back(row);
  endfunction

  function automatic int pick_job();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 6);
    return $urandom_range(1, 255);
  endfunction

  function automatic req_t random_req();
    req_t r;
    logic [95:0] raw;
    int sel;
    raw = {$urandom, $urandom, $urandom};
    r = raw[$bits(req_t)-1:0];
    sel = $urandom_range(0, 99);
    if ($urandom_range(0, 1) == 0) r.part_size = SIZE_W'($urandom_range(0, 1023));
    case ($urandom_range(0, 3))
      0: r.job_size = SIZE_W'($urandom_range(0, 255));
      1: r.job_size = SIZE_W'($urandom_range(0, 1023));
      default: r.job_size = SIZE_W'($urandom);
    endcase
    if (sel < 25) begin
      r.cmd = CMD_LOAD;
    end else if (sel < 65) begin
      r.cmd = CMD_ALLOC;
      r.job_id = JOB_W'(pick_job());
    end else if (sel < 92) begin
      r.cmd = CMD_REL;
      r.job_id = JOB_W'(pick_job());
    end else if (sel < 95) begin
      r.cmd = CMD_UNUSED;
    end else begin
      r.cmd = ($urandom_range(0, 1) == 0) ? CMD_ALLOC : CMD_REL;
      r.job_id = JOB_FREE;
    end
    return r;
  endfunction

  task automatic issue(input req_t r, input bit typed, input res_t typed_res);
    res_t pred;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= r.cmd;
    in_part_index <= r.part_index;
    in_part_size <= r.part_size;
    in_part_base <= r.part_base;
    in_job_id <= r.job_id;
    in_job_size <= r.job_size;
    do @(posedge clk); while (in_stall);
    pred = alloc_outcome(r);
    pending_res.push_back(typed ? typed_res : pred);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_part_count(input logic [PCNT_W-1:0] cnt);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= cnt;
    @(posedge clk);
    cfg_we <= 1'b0;
    scan_count = cnt;
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      err_cnt++;
    end
  endtask

  // receiver back-pressure in bursts of random length
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_res.size() == 0) begin
        $display("%0t: result beat with nothing pending, expected none, got status %0d",
                 $time, out_status);
        err_cnt++;
      end else begin
        want_res = pending_res.pop_front();
        check_field("status", want_res.status, out_status);
        check_field("granted_index", want_res.granted_index, out_granted_index);
        check_field("granted_base", want_res.granted_base, out_granted_base);
        check_field("freed_count", want_res.freed_count, out_freed_count);
      end
    end
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    int cnt;
    // directed rows, at reset the scan count is zero
    add_item(mk_req(CMD_ALLOC, 0, 0, 0, 1, 0), 1, mk_res(ST_NOFIT, 0, 0, 0));
    add_item(mk_req(CMD_REL, 0, 0, 0, 1, 0), 1, mk_res(ST_NOTFND, 0, 0, 0));
    add_item(mk_req(CMD_UNUSED, 15, 'hFFFF, 'hFFFFF, 255, 'hFFFF), 1, mk_res(ST_BAD, 0, 0, 0));
    add_item(mk_req(CMD_ALLOC, 7, 'hFFFF, 'hFFFFF, JOB_FREE, 'h1234), 1, mk_res(ST_BAD, 0, 0, 0));
    add_item(mk_req(CMD_REL, 7, 'hFFFF, 'hFFFFF, JOB_FREE, 'hFFFF), 1, mk_res(ST_BAD, 0, 0, 0));
    // fill every slot before any scan can reach it
    add_item(mk_req(CMD_LOAD, 0, 0, 0, 0, 0), 1, mk_res(ST_OK, 0, 0, 0));
    for (int i = 1; i < NUM_PARTITIONS - 1; i++) begin
      add_item(mk_req(CMD_LOAD, i, $urandom_range(1, 'hFFFE), $urandom, 0, 0), 0, '0);
    end
    add_item(mk_req(CMD_LOAD, 15, 'hFFFF, 'hFFFFF, 0, 0), 1, mk_res(ST_OK, 0, 0, 0));
    // count above the table size scans all slots
    add_cfg(31);
    add_item(mk_req(CMD_ALLOC, 0, 0, 0, 255, 0), 1, mk_res(ST_OK, 0, 0, 0));
    add_item(mk_req(CMD_ALLOC, 0, 0, 0, 255, 'hFFFF), 0, '0);
    add_item(mk_req(CMD_ALLOC, 0, 0, 0, 254, 'hFFFF), 0, '0);
    add_item(mk_req(CMD_REL, 0, 0, 0, 255, 0), 1, mk_res(ST_OK, 0, 0, 2));
    add_item(mk_req(CMD_REL, 0, 0, 0, 255, 0), 1, mk_res(ST_NOTFND, 0, 0, 0));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    gap_pct = 30;
    stall_pct = 30;
    foreach (stim_rows[k]) begin
      if (stim_rows[k].kind == ROW_CFG) write_part_count(stim_rows[k].count);
      else issue(stim_rows[k].req, stim_rows[k].typed, stim_rows[k].res);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: cnt = 16;
        1: cnt = 1;
        2: cnt = 0;
        3: cnt = 8;
        4: cnt = 31;
        5: cnt = 17;
        6: cnt = $urandom_range(0, 31);
        7: cnt = $urandom_range(2, 15);
        8: cnt = 3;
        default: cnt = 16;
      endcase
      write_part_count(cnt[PCNT_W-1:0]);
      // every third phase runs without idling, the last one too
      if (p == NUM_PHASES - 1 || p % 3 == 1) gap_pct = 0;
      else gap_pct = (p % 3 == 0) ? 30 : 60;
      stall_pct = gap_pct;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        issue(random_req(), 0, '0);
      end
    end

    drain();
    if (err_cnt == 0 && pending_res.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
